// File: hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion forms for the port checker module.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define CHK_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled during reset
`define CHK_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: hdl/crcfrm_pkg.sv
// ----------------------------------------------------------------------------
// CRC frame receive package
// Frame byte positions, match constants, CRC16 byte update and the
// transaction struct between the input stage and the frame logic.
// ----------------------------------------------------------------------------
package crcfrm_pkg;

   localparam logic [15:0] CRC_INIT  = 16'hFFFF;
   localparam logic [15:0] CRC_POLY  = 16'h1021;
   localparam logic [7:0]  START_ONE = 8'hFA;
   localparam logic [7:0]  START_TWO = 8'hFB;
   localparam logic [7:0]  CMD_HP    = 8'h41;

   typedef enum logic [2:0] {
      POS_SYNC_A,
      POS_SYNC_B,
      POS_CMD,
      POS_LEN,
      POS_HP,
      POS_CRC_LO,
      POS_CRC_HI
   } pos_type;

   typedef struct packed {
      logic       valid;
      logic [7:0] data;
   } byte_xfer_type;

   // CRC16-CCITT, MSB first, one byte
   function automatic logic [15:0] crc_take_byte(input logic [15:0] crc,
                                                 input logic [7:0]  data);
      logic [15:0] c;
      c = crc ^ {data, 8'h00};
      for (int k = 0; k < 8; k++) begin
         c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
      end
      return c;
   endfunction

endpackage

// File: hdl/crcfrm_in_stage.sv
// ----------------------------------------------------------------------------
// CRC frame input stage
// Registers one received byte and holds it until the frame logic takes it.
// ----------------------------------------------------------------------------
module crcfrm_in_stage (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic [7:0]                req_rx_byte,
   output crcfrm_pkg::byte_xfer_type out_xfer,
   input  logic                      out_take
);
   import crcfrm_pkg::*;

   logic       valid_ff, valid_in;
   logic [7:0] data_ff, data_in;
   logic       req_accept;

   assign req_ready  = !valid_ff || out_take;
   assign req_accept = req_valid && req_ready;

   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      if (req_accept) begin
         valid_in = 1'b1;
         data_in  = req_rx_byte;
      end else if (out_take) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign out_xfer.valid = valid_ff;
   assign out_xfer.data  = data_ff;

endmodule

// File: hdl/crcfrm_frame.sv
// ----------------------------------------------------------------------------
// CRC frame logic
// Tracks the byte position within a seven-byte frame, runs the CRC, checks
// start and command bytes and registers one result per frame.
// ----------------------------------------------------------------------------
module crcfrm_frame (
   input  logic                      clock,
   input  logic                      reset,
   input  crcfrm_pkg::byte_xfer_type in_xfer,
   output logic                      in_take,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic [7:0]                rsp_hp,
   output logic                      rsp_frame_ok
);
   import crcfrm_pkg::*;

   pos_type     pos_ff, pos_in;
   logic [15:0] crc_ff, crc_in;
   logic        hdr_ff, hdr_in;
   logic [7:0]  hp_held_ff, hp_held_in;
   logic [7:0]  crc_lo_ff, crc_lo_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [7:0]  rsp_hp_ff, rsp_hp_in;
   logic        rsp_ok_ff, rsp_ok_in;

   logic [15:0] crc_next;
   logic        last_byte;
   logic        slot_free;
   logic        frame_good;

   assign crc_next   = crc_take_byte(crc_ff, in_xfer.data);
   assign last_byte  = (pos_ff != POS_SYNC_A) && (pos_ff != POS_SYNC_B) &&
                       (pos_ff != POS_CMD) && (pos_ff != POS_LEN) &&
                       (pos_ff != POS_HP) && (pos_ff != POS_CRC_LO);
   assign slot_free  = !rsp_valid_ff || rsp_ready;
   // bytes that finish no frame never wait on the result side
   assign in_take    = in_xfer.valid && (!last_byte || slot_free);
   assign frame_good = hdr_ff && ({in_xfer.data, crc_lo_ff} == crc_ff);

   always_comb begin
      pos_in       = pos_ff;
      crc_in       = crc_ff;
      hdr_in       = hdr_ff;
      hp_held_in   = hp_held_ff;
      crc_lo_in    = crc_lo_ff;
      rsp_hp_in    = rsp_hp_ff;
      rsp_ok_in    = rsp_ok_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (in_take) begin
         case (pos_ff)
            POS_SYNC_A: begin
               if (in_xfer.data != START_ONE) hdr_in = 1'b0;
               crc_in = crc_next;
               pos_in = POS_SYNC_B;
            end
            POS_SYNC_B: begin
               if (in_xfer.data != START_TWO) hdr_in = 1'b0;
               crc_in = crc_next;
               pos_in = POS_CMD;
            end
            POS_CMD: begin
               if (in_xfer.data != CMD_HP) hdr_in = 1'b0;
               crc_in = crc_next;
               pos_in = POS_LEN;
            end
            POS_LEN: begin
               crc_in = crc_next;
               pos_in = POS_HP;
            end
            POS_HP: begin
               hp_held_in = in_xfer.data;
               crc_in     = crc_next;
               pos_in     = POS_CRC_LO;
            end
            POS_CRC_LO: begin
               crc_lo_in = in_xfer.data;
               pos_in    = POS_CRC_HI;
            end
            default: begin
               // CRC high byte: close the frame and load the result
               rsp_valid_in = 1'b1;
               rsp_hp_in    = hp_held_ff;
               rsp_ok_in    = frame_good;
               pos_in       = POS_SYNC_A;
               crc_in       = CRC_INIT;
               hdr_in       = 1'b1;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= POS_SYNC_A;
         crc_ff       <= CRC_INIT;
         hdr_ff       <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         pos_ff       <= pos_in;
         crc_ff       <= crc_in;
         hdr_ff       <= hdr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      hp_held_ff <= hp_held_in;
      crc_lo_ff  <= crc_lo_in;
      rsp_hp_ff  <= rsp_hp_in;
      rsp_ok_ff  <= rsp_ok_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_hp       = rsp_hp_ff;
   assign rsp_frame_ok = rsp_ok_ff;

endmodule

// File: hdl/crc16_frame_receive_checker.sv
// ----------------------------------------------------------------------------
// CRC16 frame receive checker
// Checks seven-byte framed packets and reports the payload with a pass flag.
// ----------------------------------------------------------------------------
// Received bytes are taken in fixed groups of seven counted from reset, with
// no hunting for the start bytes: 0xFA, 0xFB, command, length, payload, CRC
// low, CRC high. The CRC16-CCITT (init 0xFFFF, poly 0x1021, MSB first) runs
// over the first five bytes of a group. One byte is accepted every clock
// unless the input stalls; a byte waits in an input register until the
// frame logic folds it into the frame state, and taking a frame's last byte
// registers its result for rsp_. Input stalls only while a finished result
// waits in the output register and the next frame's last byte is in hand.
module crc16_frame_receive_checker (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_rx_byte,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_hp,
   output logic       rsp_frame_ok
);
   import crcfrm_pkg::*;

   byte_xfer_type byte_xfer;
   logic          byte_take;

   crcfrm_in_stage u_in_stage (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_rx_byte (req_rx_byte),
      .out_xfer    (byte_xfer),
      .out_take    (byte_take)
   );

   crcfrm_frame u_frame (
      .clock        (clock),
      .reset        (reset),
      .in_xfer      (byte_xfer),
      .in_take      (byte_take),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_hp       (rsp_hp),
      .rsp_frame_ok (rsp_frame_ok)
   );

endmodule

// File: hdl/crcfrm_checker.sv
// ----------------------------------------------------------------------------
// CRC frame port checker
// Watches the top-level ports: result count per frame, hold and rate.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module crcfrm_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_hp,
   input logic       rsp_frame_ok
);
   import crcfrm_pkg::*;

   pos_type    cnt_ff, cnt_in;
   logic [2:0] pending_ff, pending_in;
   logic       req_accept, rsp_accept, frame_done;

   assign req_accept = req_valid && req_ready;
   assign rsp_accept = rsp_valid && rsp_ready;
   assign frame_done = req_accept && (cnt_ff == POS_CRC_HI);

   always_comb begin
      cnt_in = cnt_ff;
      if (req_accept) begin
         cnt_in = (cnt_ff == POS_CRC_HI) ? POS_SYNC_A : pos_type'(cnt_ff + 3'd1);
      end
      pending_in = pending_ff + {2'b00, frame_done} - {2'b00, rsp_accept};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff     <= POS_SYNC_A;
         pending_ff <= 3'd0;
      end else begin
         cnt_ff     <= cnt_in;
         pending_ff <= pending_in;
      end
   end

   `CHK_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_hp) && $stable(rsp_frame_ok), "result transaction changed while stalled")
   `CHK_IMPLY(a_rsp_owed, clock, reset, rsp_valid, pending_ff != 3'd0, "result shown with no completed frame pending")
   `CHK_IMPLY(a_pending_max, clock, reset, 1'b1, pending_ff <= 3'd2, "more than two frame results in flight")
   `CHK_IMPLY(a_ready_rate, clock, reset, !req_ready, rsp_valid && !rsp_ready, "input stalled without a blocked result")

endmodule

bind crc16_frame_receive_checker crcfrm_checker u_crcfrm_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_valid),
   .req_ready    (req_ready),
   .rsp_valid    (rsp_valid),
   .rsp_ready    (rsp_ready),
   .rsp_hp       (rsp_hp),
   .rsp_frame_ok (rsp_frame_ok)
);

// File: verif/crc16_frame_receive_checker_tb.sv
// ----------------------------------------------------------------------------
// CRC16 frame receive checker testbench
// Sends seven-byte frames (good, corrupted, misaligned and noise) under
// random sender bursts and receiver stalls. Each accepted byte goes through
// a local frame predictor. Every reported frame is checked against the
// oldest predicted result.
// ----------------------------------------------------------------------------
module crc16_frame_receive_checker_tb;
   import crcfrm_pkg::*;

   localparam int CYCLE_LIMIT = 400000;
   localparam int MAX_SHOWN   = 10;

   typedef struct packed {
      logic [7:0] hp;
      logic       frame_ok;
   } frame_result_t;

   logic       clock;
   logic       reset;
   logic       req_valid;
   logic       req_ready;
   logic [7:0] req_rx_byte;
   logic       rsp_valid;
   logic       rsp_ready;
   logic [7:0] rsp_hp;
   logic       rsp_frame_ok;

   // predictor state
   pos_type     rx_pos;
   logic [15:0] rx_crc;
   logic        rx_header_good;
   logic [7:0]  rx_hp;
   logic [7:0]  rx_crc_lo;

   frame_result_t expected_frames[$];

   int err_count;
   int mismatch_count;
   int bytes_sent;
   int frames_checked;
   int frames_passed;
   int cycle_count;

   // sender bursts and receiver stall pattern
   int burst_left;
   int gap_max;
   int stall_pct;
   int stall_run_max;
   int stall_run;

   crc16_frame_receive_checker dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_rx_byte  (req_rx_byte),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_hp       (rsp_hp),
      .rsp_frame_ok (rsp_frame_ok)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   // CRC16-CCITT, one byte, bit serial MSB first
   function automatic logic [15:0] frame_crc_next(input logic [15:0] acc,
                                                  input logic [7:0]  b);
      logic [15:0] r;
      r = acc;
      for (int i = 7; i >= 0; i--) begin
         if (r[15] ^ b[i]) begin
            r = {r[14:0], 1'b0} ^ CRC_POLY;
         end else begin
            r = {r[14:0], 1'b0};
         end
      end
      return r;
   endfunction

   task automatic clear_frame_state();
      rx_pos         = POS_SYNC_A;
      rx_crc         = CRC_INIT;
      rx_header_good = 1'b1;
   endtask

   task automatic predict_frame_byte(input logic [7:0] b);
      frame_result_t res;
      case (rx_pos)
         POS_SYNC_A: begin
            if (b != START_ONE) rx_header_good = 1'b0;
            rx_crc = frame_crc_next(rx_crc, b);
            rx_pos = POS_SYNC_B;
         end
         POS_SYNC_B: begin
            if (b != START_TWO) rx_header_good = 1'b0;
            rx_crc = frame_crc_next(rx_crc, b);
            rx_pos = POS_CMD;
         end
         POS_CMD: begin
            if (b != CMD_HP) rx_header_good = 1'b0;
            rx_crc = frame_crc_next(rx_crc, b);
            rx_pos = POS_LEN;
         end
         POS_LEN: begin
            // length goes into the CRC but is never compared
            rx_crc = frame_crc_next(rx_crc, b);
            rx_pos = POS_HP;
         end
         POS_HP: begin
            rx_hp  = b;
            rx_crc = frame_crc_next(rx_crc, b);
            rx_pos = POS_CRC_LO;
         end
         POS_CRC_LO: begin
            rx_crc_lo = b;
            rx_pos    = POS_CRC_HI;
         end
         default: begin
            res.hp       = rx_hp;
            res.frame_ok = rx_header_good && ({b, rx_crc_lo} == rx_crc);
            expected_frames.push_back(res);
            clear_frame_state();
         end
      endcase
   endtask

   // Entered and left at a falling edge; one transaction per call.
   task automatic push_byte(input logic [7:0] b);
      int gap;
      if (gap_max > 0 && burst_left == 0) begin
         burst_left = $urandom_range(12, 1);
         gap        = $urandom_range(gap_max, 1);
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      if (burst_left > 0) burst_left--;
      req_valid   <= 1'b1;
      req_rx_byte <= b;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predict_frame_byte(b);
      bytes_sent++;
      @(negedge clock);
   endtask

   // crc_flip corrupts the transmitted CRC
   task automatic send_frame(input logic [7:0] s1, input logic [7:0] s2,
                             input logic [7:0] cmd, input logic [7:0] len,
                             input logic [7:0] hp, input logic [15:0] crc_flip);
      logic [15:0] c;
      c = CRC_INIT;
      c = frame_crc_next(c, s1);
      c = frame_crc_next(c, s2);
      c = frame_crc_next(c, cmd);
      c = frame_crc_next(c, len);
      c = frame_crc_next(c, hp);
      c = c ^ crc_flip;
      push_byte(s1);
      push_byte(s2);
      push_byte(cmd);
      push_byte(len);
      push_byte(hp);
      push_byte(c[7:0]);
      push_byte(c[15:8]);
   endtask

   task automatic set_idling(input int gaps, input int stall_chance, input int stall_len);
      gap_max       = gaps;
      burst_left    = 0;
      stall_pct     = stall_chance;
      stall_run_max = stall_len;
   endtask

   task automatic send_random_frame();
      logic [7:0]  s1, s2, cmd;
      logic [15:0] flip;
      int          pick;
      s1   = START_ONE;
      s2   = START_TWO;
      cmd  = CMD_HP;
      flip = '0;
      pick = $urandom_range(99);
      if (pick >= 94) begin
         // pure noise group
         repeat (7) push_byte(8'($urandom_range(255)));
         return;
      end
      if (pick >= 65) begin
         case ($urandom_range(4))
            0: s1 = START_ONE ^ 8'($urandom_range(255, 1));
            1: s2 = START_TWO ^ 8'($urandom_range(255, 1));
            2: cmd = CMD_HP ^ 8'($urandom_range(255, 1));
            3: flip = {8'($urandom_range(255, 1)), 8'h00};
            default: flip = {8'h00, 8'($urandom_range(255, 1))};
         endcase
      end
      send_frame(s1, s2, cmd, 8'($urandom_range(255)), 8'($urandom_range(255)), flip);
   endtask

   task automatic test_directed_frames();
      set_idling(0, 0, 1);
      send_frame(START_ONE, START_TWO, CMD_HP, 8'h00, 8'hFF, 16'h0000);
      send_frame(START_ONE, START_TWO, CMD_HP, 8'hFF, 8'h00, 16'h0000);
      // wrong command with a CRC that matches the bytes sent
      send_frame(START_ONE, START_TWO, 8'h42, 8'h07, 8'h5A, 16'h0000);
   endtask

   task automatic test_random_frames(input int count);
      repeat (count) send_random_frame();
   endtask

   // Shift good frames off the group boundary, then realign.
   task automatic test_misaligned_stream(input int rounds);
      int k;
      repeat (rounds) begin
         k = $urandom_range(6, 1);
         repeat (k) push_byte(8'($urandom_range(255)));
         repeat (3) begin
            send_frame(START_ONE, START_TWO, CMD_HP, 8'($urandom_range(255)),
                       8'($urandom_range(255)), 16'h0000);
         end
         repeat (7 - k) push_byte(8'($urandom_range(255)));
      end
   endtask

   // receiver: random runs of ready or stall
   always @(negedge clock) begin
      if (stall_run == 0) begin
         stall_run = $urandom_range(stall_run_max, 1);
         rsp_ready <= ($urandom_range(99) >= stall_pct);
      end
      stall_run--;
   end

   always @(posedge clock) begin
      frame_result_t want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_frames.size() == 0) begin
            err_count++;
            mismatch_count++;
            if (mismatch_count <= MAX_SHOWN) begin
               $display("unexpected frame result: hp=%02h frame_ok=%0b",
                        rsp_hp, rsp_frame_ok);
            end
         end else begin
            want = expected_frames.pop_front();
            frames_checked++;
            if (want.frame_ok) frames_passed++;
            if (rsp_hp !== want.hp) begin
               err_count++;
               mismatch_count++;
               if (mismatch_count <= MAX_SHOWN) begin
                  $display("hp mismatch: expected %02h, got %02h", want.hp, rsp_hp);
               end
            end
            if (rsp_frame_ok !== want.frame_ok) begin
               err_count++;
               mismatch_count++;
               if (mismatch_count <= MAX_SHOWN) begin
                  $display("frame_ok mismatch (hp %02h): expected %0b, got %0b",
                           want.hp, want.frame_ok, rsp_frame_ok);
               end
            end
         end
      end
   end

   initial begin
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_rx_byte    = 8'h00;
      rsp_ready      = 1'b0;
      err_count      = 0;
      mismatch_count = 0;
      bytes_sent     = 0;
      frames_checked = 0;
      frames_passed  = 0;
      cycle_count    = 0;
      stall_run      = 0;
      burst_left     = 0;
      gap_max        = 0;
      stall_pct      = 0;
      stall_run_max  = 1;
      rx_hp          = 8'h00;
      rx_crc_lo      = 8'h00;
      clear_frame_state();
      repeat (2) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_directed_frames();
      set_idling(0, 0, 1);
      test_random_frames(50);
      set_idling(4, 30, 3);
      test_random_frames(50);
      set_idling(10, 60, 8);
      test_random_frames(50);
      set_idling(3, 40, 4);
      test_misaligned_stream(10);

      req_valid <= 1'b0;
      while (expected_frames.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (expected_frames.size() != 0) err_count++;

      $display("Sent %0d bytes; checked %0d frames, %0d expected to pass and %0d to fail",
               bytes_sent, frames_checked, frames_passed, frames_checked - frames_passed);
      $display("Covered bad start and command bytes, CRC corruption, noise and misalignment");
      if (err_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
